[hw/rtl/pcx_rle_decoder_defines.svh]
// ----------------------------------------------------------------------------
// pcx_rle_decoder_defines
// assertion macros used by the pcx run-length decoder datapath
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_DECODER_DEFINES_SVH
`define PCX_RLE_DECODER_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define PCXD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define PCXD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pcxd_pkg.sv]
// ----------------------------------------------------------------------------
// pcxd_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package pcxd_pkg;

    // fixed field widths
    localparam int CODE_W    = 8;
    localparam int ADDR_W    = 24;
    localparam int CFG_W     = 13;
    localparam int COUNT_W   = 6;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // default largest image dimension
    localparam int MAX_DIM_DEF = 4096;

    // code byte fields
    localparam logic [CODE_W-1:0] MARKER_BITS = 8'hC0;
    localparam logic [CODE_W-1:0] COUNT_BITS  = 8'h3F;

    // register map, indexed by paddr[2]
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // datapath commands from the controller
    typedef struct packed {
        logic drop;   // byte after image end, ignored
        logic mark;   // run marker, latch count
        logic skip;   // zero-length run value byte
        logic first;  // first pixel from accepted byte
        logic step;   // next pixel of a run
    } t_dp_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic marker;      // current byte is a run marker
        logic cnt_zero;    // byte yields no pixel
        logic first_last;  // byte yields exactly one pixel
        logic step_last;   // run pixel in flight is its last
        logic done;        // image complete
        logic out_free;    // output register can take a pixel
    } t_dp_status;

endpackage

`default_nettype wire

[hw/rtl/pcxd_ctrl.sv]
// ----------------------------------------------------------------------------
// pcxd_ctrl
// byte intake and run sequencing state machine
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_ctrl
    import pcxd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic {
        S_TAKE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   live;

    // input handshake, only when a pixel could be placed
    assign o_in_ready = (r_state == S_TAKE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign live       = accept && !i_status.done;

    // command decode
    always_comb begin
        o_cmd       = '0;
        o_cmd.drop  = accept && i_status.done;
        o_cmd.mark  = live && i_status.marker;
        o_cmd.skip  = live && !i_status.marker && i_status.cnt_zero;
        o_cmd.first = live && !i_status.marker && !i_status.cnt_zero;
        o_cmd.step  = (r_state == S_RUN) && i_status.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_TAKE: begin
                if (o_cmd.first && !i_status.first_last) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.step && i_status.step_last) begin
                    n_state = S_TAKE;
                end
            end
            default: n_state = S_TAKE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pcxd_datapath.sv]
// ----------------------------------------------------------------------------
// pcxd_datapath
// run registers, image position, bounds check and output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcx_rle_decoder_defines.svh"

module pcxd_datapath
    import pcxd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic [CODE_W-1:0] i_code_byte,
    input  wire logic [CFG_W-1:0]  i_width_reg,
    input  wire logic [CFG_W-1:0]  i_height_reg,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [ADDR_W-1:0]      o_pixel_addr,
    output logic [CODE_W-1:0]      o_pixel_value,
    output logic                   o_write_enable,
    output logic                   o_run_last,
    output logic                   o_image_done,
    output logic                   o_size_issue
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int FULL_W = 2 * DIM_W;
    localparam int CMP_W  = (FULL_W > ADDR_W + 1) ? FULL_W : ADDR_W + 1;

    // control state
    logic               r_await;
    logic [COUNT_W-1:0] r_run_count;
    logic [COUNT_W-1:0] r_left;
    logic [CFG_W-1:0]   r_column;
    logic [CFG_W-1:0]   r_row_index;
    logic [ADDR_W-1:0]  r_row_base;
    logic               r_issue;
    logic               r_done;
    logic               r_out_valid;

    // payload state
    logic [CODE_W-1:0]  r_value;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [CODE_W-1:0]  r_out_value;
    logic               r_out_we;
    logic               r_out_last;
    logic               r_out_done;
    logic               r_out_issue;

    logic [DIM_W-1:0]   width_c;
    logic [DIM_W-1:0]   height_c;
    logic [FULL_W-1:0]  full_c;
    logic [COUNT_W-1:0] eff_count;
    logic               emit;
    logic               pix_last;
    logic [CODE_W-1:0]  pix_value;
    logic [CMP_W-1:0]   pix_addr;
    logic               pix_we;
    logic [CFG_W-1:0]   col_inc;
    logic [CFG_W-1:0]   row_inc;
    logic               row_end;
    logic               img_end;
    logic               n_issue;

    // clamp dimensions to 1..MAX_DIM
    always_comb begin
        if (i_width_reg == '0) begin
            width_c = DIM_W'(1);
        end else if (i_width_reg > CFG_W'(MAX_DIM)) begin
            width_c = DIM_W'(MAX_DIM);
        end else begin
            width_c = DIM_W'(i_width_reg);
        end
        if (i_height_reg == '0) begin
            height_c = DIM_W'(1);
        end else if (i_height_reg > CFG_W'(MAX_DIM)) begin
            height_c = DIM_W'(MAX_DIM);
        end else begin
            height_c = DIM_W'(i_height_reg);
        end
    end

    // buffer size product
    assign full_c = width_c * height_c;

    // pixel count of the byte being taken
    assign eff_count = r_await ? r_run_count : COUNT_W'(1);

    // status to controller
    always_comb begin
        o_status            = '0;
        o_status.marker     = !r_await && ((i_code_byte & MARKER_BITS) == MARKER_BITS);
        o_status.cnt_zero   = (eff_count == '0);
        o_status.first_last = (eff_count == COUNT_W'(1));
        o_status.step_last  = (r_left == COUNT_W'(1));
        o_status.done       = r_done;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // one pixel: address, bounds check, row end
    assign emit      = i_cmd.first || i_cmd.step;
    assign pix_last  = i_cmd.first ? o_status.first_last : o_status.step_last;
    assign pix_value = i_cmd.first ? i_code_byte : r_value;
    assign pix_addr  = CMP_W'(r_row_base) + CMP_W'(r_column);
    assign pix_we    = pix_addr < CMP_W'(full_c);
    assign col_inc   = r_column + CFG_W'(1);
    assign row_inc   = r_row_index + CFG_W'(1);
    assign row_end   = pix_last && (col_inc >= CFG_W'(width_c));
    assign img_end   = row_end && (row_inc >= CFG_W'(height_c));
    assign n_issue   = r_issue || !pix_we;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await     <= 1'b0;
            r_run_count <= '0;
            r_left      <= '0;
            r_column    <= '0;
            r_row_index <= '0;
            r_row_base  <= '0;
            r_issue     <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mark) begin
                r_await     <= 1'b1;
                r_run_count <= COUNT_W'(i_code_byte & COUNT_BITS);
            end
            if (i_cmd.skip || i_cmd.first) begin
                r_await <= 1'b0;
            end
            // remaining pixels of the run
            if (i_cmd.first) begin
                r_left <= eff_count - COUNT_W'(1);
            end else if (i_cmd.step) begin
                r_left <= r_left - COUNT_W'(1);
            end
            // image position
            if (emit) begin
                r_issue <= n_issue;
                if (row_end) begin
                    r_column    <= '0;
                    r_row_base  <= r_row_base + ADDR_W'(width_c);
                    r_row_index <= row_inc;
                    r_done      <= r_done || img_end;
                end else begin
                    r_column <= col_inc;
                end
            end
            // output register occupancy
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.first) begin
            r_value <= i_code_byte;
        end
        if (emit) begin
            r_out_addr  <= ADDR_W'(pix_addr);
            r_out_value <= pix_value;
            r_out_we    <= pix_we;
            r_out_last  <= pix_last;
            r_out_done  <= img_end;
            r_out_issue <= n_issue;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_addr   = r_out_addr;
    assign o_pixel_value  = r_out_value;
    assign o_write_enable = r_out_we;
    assign o_run_last     = r_out_last;
    assign o_image_done   = r_out_done;
    assign o_size_issue   = r_out_issue;

    // checks
    `PCXD_ASSERT_NOW(a_no_pixel_after_done, r_done, !emit, "pixel emitted after image end")
    `PCXD_ASSERT_NOW(a_step_has_left, i_cmd.step, r_left != '0, "run step with no pixels left")
    `PCXD_ASSERT_NOW(a_drop_flags_issue, r_out_valid && !r_out_we, r_out_issue,
        "dropped write without size issue")
    `PCXD_ASSERT_NEXT(a_issue_sticky, r_issue, r_issue, "size issue flag cleared")

endmodule

`default_nettype wire

[hw/rtl/pcx_rle_decoder.sv]
// ----------------------------------------------------------------------------
// pcx_rle_decoder
// run-length decoder for the data section of 8-bit pcx images
// ----------------------------------------------------------------------------
// usage:
//   code bytes enter on i_code_byte with i_in_valid / o_in_ready; each decoded
//   pixel leaves as one transaction on o_out_valid / i_out_ready carrying the
//   linear address, palette index, write enable and run/image/issue flags.
//   image_width (0x0) and image_height (0x4) are set over the apb port, by the
//   user only while idle, unenforced by the block; values clamp to 1..MAX_DIM.
// timing:
//   a literal byte gives its pixel in the output register in the cycle after
//   it is taken, and literal bytes are taken one per cycle while the output
//   is not stalled. a marker byte gives no pixel. its value byte emits n
//   pixels, one per cycle while not stalled, through the shared address/bounds
//   unit; intake waits until the run's last pixel is issued.
// reset:
//   position, run state and flags clear; both dimensions return to 1.
// stall:
//   while the output register holds a pixel and i_out_ready is low, that
//   pixel is held, run sequencing pauses and o_in_ready stays low. bytes
//   after image end are taken and discarded until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_decoder
    import pcxd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // code byte channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [CODE_W-1:0] i_code_byte,
    // pixel write channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ADDR_W-1:0]      o_pixel_addr,
    output logic [CODE_W-1:0]      o_pixel_value,
    output logic                   o_write_enable,
    output logic                   o_run_last,
    output logic                   o_image_done,
    output logic                   o_size_issue,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             cfg_wr;
    t_reg_idx         reg_sel;
    t_dp_cmd          cmd;
    t_dp_status       status;

    // register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1);
            r_height <= CFG_W'(1);
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    // sequencing
    pcxd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // decode datapath
    pcxd_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_code_byte    (i_code_byte),
        .i_width_reg    (r_width),
        .i_height_reg   (r_height),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_pixel_addr   (o_pixel_addr),
        .o_pixel_value  (o_pixel_value),
        .o_write_enable (o_write_enable),
        .o_run_last     (o_run_last),
        .o_image_done   (o_image_done),
        .o_size_issue   (o_size_issue)
    );

endmodule

`default_nettype wire
